// ===== rtl/ntlm_pkg.sv =====
// shared types, codes and helper functions for the note to lamp mapper
package ntlm_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PROGRAM  = 2'd0;
    localparam kind_t KIND_NOTE_ON  = 2'd1;
    localparam kind_t KIND_NOTE_OFF = 2'd2;

    localparam logic [31:0] GAP_RESET  = 32'd60000;
    localparam logic [3:0]  DRUM_RESET = 4'd9;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  channel;
        logic [6:0]  program_req;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] time_us;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  lamp;
        logic        level;
    } result_t;

    typedef struct packed {
        logic [31:0] retrigger_gap;
        logic [3:0]  drum_channel;
    } cfg_t;

    // floor(x / 12) for 8-bit x by reciprocal 683 / 8192
    function automatic logic [7:0] div12(input logic [7:0] x);
        logic [20:0] prod;
        prod = {13'd0, x} * 21'd683;
        return prod[20:13];
    endfunction

    // lamp for a pitch class: (note % 12) * lamps / 12, below lamps for lamps up to 12
    function automatic logic [3:0] lamp_of(input logic [6:0] note, input int lamps);
        logic [7:0] q;
        logic [7:0] r;
        logic [7:0] scaled;
        logic [7:0] lamp_q;
        q      = div12({1'b0, note});
        r      = {1'b0, note} - 8'(q * 8'd12);
        scaled = 8'(r[3:0] * 8'(lamps));
        lamp_q = div12(scaled);
        return lamp_q[3:0];
    endfunction

    function automatic logic program_muted(input logic [6:0] p);
        return (p >= 7'd8 && p <= 7'd15) || (p >= 7'd32 && p <= 7'd39) ||
               (p >= 7'd88 && p <= 7'd103);
    endfunction

endpackage

// ===== rtl/note_to_lamp_mapper_top.sv =====
// top level: input request register, mapper core, result register and apb registers
//
// Music events in, lamp drive commands out. One event is accepted every cycle;
// an event that drives a lamp passes through the input register and then the
// result register to the result port, and events that change no lamp give no
// result. The single input register and the single result register set the
// flow: the input side stalls only while a result waits in the result register
// and m_ready is low. Configure the retrigger gap (address 0) and drum channel
// (address 4) only while no events are in flight.
module note_to_lamp_mapper_top #(
    parameter int LAMPS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [3:0]  s_channel,
    input  logic [6:0]  s_program_req,
    input  logic [6:0]  s_note,
    input  logic [6:0]  s_velocity,
    input  logic [31:0] s_time_us,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_lamp,
    output logic        m_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ntlm_pkg::*;

    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    logic    m_valid_reg, m_valid_next;
    logic [2:0] lamp_reg;
    logic    level_reg;
    logic    advance;
    cfg_t    cfg;
    result_t res;

    ntlm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ntlm_core #(.LAMPS(LAMPS)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // the held request moves on when the result register is free or draining
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = res.valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.kind        <= s_kind;
            in_item_reg.channel     <= s_channel;
            in_item_reg.program_req <= s_program_req;
            in_item_reg.note        <= s_note;
            in_item_reg.velocity    <= s_velocity;
            in_item_reg.time_us     <= s_time_us;
        end
        if (advance && res.valid) begin
            lamp_reg  <= res.lamp;
            level_reg <= res.level;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_lamp  = lamp_reg;
    assign m_level = level_reg;

    a_hold_request: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("held request lost while stalled");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg && !m_ready && in_valid_reg)
        else $error("input stalled without a waiting result");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.valid |=> m_valid_reg)
        else $error("result not captured");

endmodule

// ===== rtl/ntlm_cfg.sv =====
// apb configuration registers: retrigger gap and drum channel
module ntlm_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ntlm_pkg::cfg_t     cfg
);
    import ntlm_pkg::*;

    localparam logic REG_GAP  = 1'b0;
    localparam logic REG_DRUM = 1'b1;

    logic [31:0] gap_reg, gap_next;
    logic [3:0]  drum_reg, drum_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        gap_next  = gap_reg;
        drum_next = drum_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_GAP:  gap_next  = pwdata;
                REG_DRUM: drum_next = pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg  <= GAP_RESET;
            drum_reg <= DRUM_RESET;
        end else begin
            gap_reg  <= gap_next;
            drum_reg <= drum_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GAP:  prdata = gap_reg;
            REG_DRUM: prdata = {28'd0, drum_reg};
            default:  prdata = 32'd0;
        endcase
    end

    assign cfg.retrigger_gap = gap_reg;
    assign cfg.drum_channel  = drum_reg;

endmodule

// ===== rtl/ntlm_core.sv =====
// per-lamp slot state and the combinational event decision
module ntlm_core #(
    parameter int LAMPS = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  ntlm_pkg::item_t     item,
    input  ntlm_pkg::cfg_t      cfg,
    output ntlm_pkg::result_t   res
);
    import ntlm_pkg::*;

    localparam int LAMP_W = (LAMPS > 1) ? $clog2(LAMPS) : 1;

    logic [LAMPS-1:0] busy_reg, busy_next;
    logic [LAMPS-1:0] rel_once_reg, rel_once_next;
    logic [LAMPS-1:0] pend_reg, pend_next;
    logic [15:0]      chen_reg, chen_next;
    logic [6:0]       held_note_reg [LAMPS];
    logic [3:0]       held_ch_reg [LAMPS];
    logic [31:0]      rel_time_reg [LAMPS];

    logic [3:0]        lamp4;
    logic [LAMP_W-1:0] idx;
    logic              playable;
    logic              note_on;
    logic              take;
    logic              release_hit;
    logic              lit;
    logic [31:0]       since;

    assign lamp4 = lamp_of(item.note, LAMPS);
    assign idx   = lamp4[LAMP_W-1:0];
    assign since = item.time_us - rel_time_reg[idx];

    always_comb begin
        busy_next     = busy_reg;
        rel_once_next = rel_once_reg;
        pend_next     = pend_reg;
        chen_next     = chen_reg;
        res           = '0;
        take          = 1'b0;
        release_hit   = 1'b0;
        lit           = !rel_once_reg[idx] || (since > cfg.retrigger_gap) || pend_reg[idx];
        playable      = (item.kind == KIND_NOTE_ON || item.kind == KIND_NOTE_OFF) &&
                        (item.channel != cfg.drum_channel) && chen_reg[item.channel];
        note_on       = (item.kind == KIND_NOTE_ON) && (item.velocity != 7'd0);
        if (step) begin
            if (item.kind == KIND_PROGRAM) begin
                busy_next                = '0;
                chen_next[item.channel]  = !program_muted(item.program_req);
            end else if (playable) begin
                if (note_on) begin
                    // free lamp, or steal from a higher-numbered channel
                    if (!busy_reg[idx] || held_ch_reg[idx] > item.channel) begin
                        take           = 1'b1;
                        busy_next[idx] = 1'b1;
                        pend_next[idx] = !lit;
                        res.valid      = 1'b1;
                        res.lamp       = lamp4[2:0];
                        res.level      = lit;
                    end
                end else if (busy_reg[idx] && held_note_reg[idx] == item.note &&
                             held_ch_reg[idx] == item.channel) begin
                    release_hit        = 1'b1;
                    busy_next[idx]     = 1'b0;
                    rel_once_next[idx] = 1'b1;
                    res.valid          = 1'b1;
                    res.lamp           = lamp4[2:0];
                    res.level          = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= '0;
            rel_once_reg <= '0;
            pend_reg     <= '0;
            chen_reg     <= '1;
        end else begin
            busy_reg     <= busy_next;
            rel_once_reg <= rel_once_next;
            pend_reg     <= pend_next;
            chen_reg     <= chen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            held_note_reg[idx] <= item.note;
            held_ch_reg[idx]   <= item.channel;
        end
        if (release_hit) begin
            rel_time_reg[idx] <= item.time_us;
        end
    end

    a_prog_frees_all: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.kind == KIND_PROGRAM |=> busy_reg == '0)
        else $error("program change left a lamp busy");

    a_take_marks_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> busy_reg[$past(idx)])
        else $error("taken lamp not marked busy");

    a_no_drum_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> step && item.channel != cfg.drum_channel)
        else $error("result on drum channel or without a step");

endmodule
